// File: design/chacha_pkg.sv
// Shared types, constants and helpers for the ChaCha20 stream cipher block.
package chacha_pkg;

	typedef logic [31:0] word_t;

	// Block function depth
	localparam int DOUBLE_ROUNDS = 10;
	localparam int ROUND_HALVES  = 2 * DOUBLE_ROUNDS;
	localparam int HALF_W        = $clog2(ROUND_HALVES);

	// Constant row of the initial state ("expand 32-byte k")
	localparam word_t SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_KEY_PART0   = 3'd0,
		CFG_KEY_PART1   = 3'd1,
		CFG_KEY_PART2   = 3'd2,
		CFG_KEY_PART3   = 3'd3,
		CFG_NONCE_LOW   = 3'd4,
		CFG_NONCE_HIGH  = 3'd5,
		CFG_START_COUNT = 3'd6
	} cfg_index_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// Rotate left by the amount that belongs to quarter-round step 0..3
	function automatic word_t arx_rot(input word_t v, input logic [1:0] step);
		word_t res;
		case (step)
			2'd0:    res = {v[15:0], v[31:16]};
			2'd1:    res = {v[19:0], v[31:20]};
			2'd2:    res = {v[23:0], v[31:24]};
			default: res = {v[24:0], v[31:25]};
		endcase
		return res;
	endfunction

	// Keep only the valid low bytes of a word
	function automatic word_t byte_mask(input logic [2:0] count);
		word_t res;
		case (count)
			3'd0:    res = 32'h0000_0000;
			3'd1:    res = 32'h0000_00ff;
			3'd2:    res = 32'h0000_ffff;
			3'd3:    res = 32'h00ff_ffff;
			default: res = 32'hffff_ffff;
		endcase
		return res;
	endfunction

endpackage

// File: design/chacha20_stream_cipher.sv
// ChaCha20 stream cipher: word-serial XOR with keystream from an iterative ARX unit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  cfg      | cfg_valid / cfg_ready     | cfg_index[2:0], cfg_data[63:0]
//  data     | data_valid / data_ready   | data_word, valid_bytes, last
//  result   | result_valid/result_ready | out_word, out_valid_bytes, out_last
//
// A word that opens a keystream block first loads the initial state, then
// the four-lane ARX unit does one add-xor-rotate step per cycle, 80 steps for 20
// rounds, then adds the initial state back one row per cycle, then emits. Other
// words are transferred, then emitted.
// Reset clears config, counter, word index and sets the message-start flag.
// A stalled result port holds a finished word in the output register; the next
// data word is taken meanwhile and waits in the emit state for that register.
module chacha20_stream_cipher (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// message words
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	// processed words
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_valid_bytes,
	output logic        out_last
);

	// Configuration registers
	logic [63:0] key_part0_q, key_part1_q, key_part2_q, key_part3_q, nonce_low_q;
	logic [31:0] nonce_high_q, start_counter_q;

	// Sequencer and message state
	chacha_pkg::state_t            state_q;
	logic [1:0]                    step_q;
	logic [chacha_pkg::HALF_W-1:0] half_q;
	logic [31:0]                   blk_ctr_q;
	logic [31:0]                   init_ctr_q;
	logic [3:0]                    word_idx_q;
	logic                          msg_start_q;

	// Held data word
	logic [31:0] item_word_q;
	logic [2:0]  item_bytes_q;
	logic        item_last_q;
	logic [3:0]  item_idx_q;

	// Working state / keystream block, row by column
	chacha_pkg::word_t w_q    [4][4];
	chacha_pkg::word_t w_n    [4][4];
	chacha_pkg::word_t w_upd  [4][4];
	chacha_pkg::word_t init_w [4][4];

	// Shared ARX lanes
	chacha_pkg::word_t add_x [4];
	chacha_pkg::word_t add_y [4];
	chacha_pkg::word_t xor_r [4];
	chacha_pkg::word_t sum   [4];
	chacha_pkg::word_t rot   [4];

	logic        data_xfer;
	logic        result_xfer;
	logic        need_block;
	logic [31:0] ctr_sel;
	logic [31:0] ctr_init;
	logic [3:0]  idx_sel;
	logic        last_half;
	logic        out_free;

	assign cfg_ready   = 1'b1;
	assign data_ready  = (state_q == chacha_pkg::ST_IDLE);
	assign data_xfer   = data_valid && data_ready;
	assign result_xfer = result_valid && result_ready;
	assign out_free    = !result_valid || result_ready;

	// Pick counter and word slot for the incoming word
	assign ctr_sel    = msg_start_q ? start_counter_q : blk_ctr_q;
	assign idx_sel    = msg_start_q ? 4'd0 : word_idx_q;
	assign need_block = (idx_sel == 4'd0);
	assign last_half  = (half_q == chacha_pkg::HALF_W'(chacha_pkg::ROUND_HALVES - 1));
	assign ctr_init   = (state_q == chacha_pkg::ST_IDLE) ? ctr_sel : init_ctr_q;

	// Build the initial block state from config and counter
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			init_w[0][c] = chacha_pkg::SIGMA[c];
		end
		init_w[1][0] = key_part0_q[31:0];
		init_w[1][1] = key_part0_q[63:32];
		init_w[1][2] = key_part1_q[31:0];
		init_w[1][3] = key_part1_q[63:32];
		init_w[2][0] = key_part2_q[31:0];
		init_w[2][1] = key_part2_q[63:32];
		init_w[2][2] = key_part3_q[31:0];
		init_w[2][3] = key_part3_q[63:32];
		init_w[3][0] = ctr_init;
		init_w[3][1] = nonce_low_q[31:0];
		init_w[3][2] = nonce_low_q[63:32];
		init_w[3][3] = nonce_high_q;
	end

	// Route operands into the four lanes: ARX step or final row add
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (state_q == chacha_pkg::ST_FINAL) begin
				add_x[j] = w_q[step_q][j];
				add_y[j] = init_w[step_q][j];
				xor_r[j] = w_q[3][j];
			end else if (!step_q[0]) begin
				add_x[j] = w_q[0][j];
				add_y[j] = w_q[1][j];
				xor_r[j] = w_q[3][j];
			end else begin
				add_x[j] = w_q[2][j];
				add_y[j] = w_q[3][j];
				xor_r[j] = w_q[1][j];
			end
			sum[j] = add_x[j] + add_y[j];
			rot[j] = chacha_pkg::arx_rot(xor_r[j] ^ sum[j], step_q);
		end
	end

	// Next working state; rows 1..3 shift between column and diagonal halves
	always_comb begin
		w_upd = w_q;
		w_n   = w_q;
		case (state_q)
			chacha_pkg::ST_IDLE: begin
				if (data_xfer && need_block) begin
					w_n = init_w;
				end
			end
			chacha_pkg::ST_ROUND: begin
				for (int j = 0; j < 4; j++) begin
					if (!step_q[0]) begin
						w_upd[0][j] = sum[j];
						w_upd[3][j] = rot[j];
					end else begin
						w_upd[2][j] = sum[j];
						w_upd[1][j] = rot[j];
					end
				end
				w_n = w_upd;
				if (step_q == 2'd3) begin
					for (int j = 0; j < 4; j++) begin
						if (!half_q[0]) begin
							w_n[1][j] = w_upd[1][(j + 1) % 4];
							w_n[2][j] = w_upd[2][(j + 2) % 4];
							w_n[3][j] = w_upd[3][(j + 3) % 4];
						end else begin
							w_n[1][j] = w_upd[1][(j + 3) % 4];
							w_n[2][j] = w_upd[2][(j + 2) % 4];
							w_n[3][j] = w_upd[3][(j + 1) % 4];
						end
					end
				end
			end
			chacha_pkg::ST_FINAL: begin
				for (int j = 0; j < 4; j++) begin
					w_n[step_q][j] = sum[j];
				end
			end
			default: begin
				w_n = w_q;
			end
		endcase
	end

	// Hold the working state
	always_ff @(posedge clk) begin
		w_q <= w_n;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_part0_q     <= '0;
			key_part1_q     <= '0;
			key_part2_q     <= '0;
			key_part3_q     <= '0;
			nonce_low_q     <= '0;
			nonce_high_q    <= '0;
			start_counter_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chacha_pkg::CFG_KEY_PART0:   key_part0_q     <= cfg_data;
				chacha_pkg::CFG_KEY_PART1:   key_part1_q     <= cfg_data;
				chacha_pkg::CFG_KEY_PART2:   key_part2_q     <= cfg_data;
				chacha_pkg::CFG_KEY_PART3:   key_part3_q     <= cfg_data;
				chacha_pkg::CFG_NONCE_LOW:   nonce_low_q     <= cfg_data;
				chacha_pkg::CFG_NONCE_HIGH:  nonce_high_q    <= cfg_data[31:0];
				chacha_pkg::CFG_START_COUNT: start_counter_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Capture the data word on transfer
	always_ff @(posedge clk) begin
		if (data_xfer) begin
			item_word_q  <= data_word;
			item_bytes_q <= valid_bytes;
			item_last_q  <= last;
			item_idx_q   <= idx_sel;
		end
		if (data_xfer && need_block) begin
			init_ctr_q <= ctr_sel;
		end
	end

	// Sequencer: load, rounds, final add, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chacha_pkg::ST_IDLE;
			step_q      <= '0;
			half_q      <= '0;
			blk_ctr_q   <= '0;
			word_idx_q  <= '0;
			msg_start_q <= 1'b1;
		end else begin
			case (state_q)
				chacha_pkg::ST_IDLE: begin
					if (data_xfer) begin
						word_idx_q  <= idx_sel + 4'd1;
						msg_start_q <= last;
						step_q      <= '0;
						half_q      <= '0;
						if (need_block) begin
							blk_ctr_q <= ctr_sel + 32'd1;
							state_q   <= chacha_pkg::ST_ROUND;
						end else begin
							state_q <= chacha_pkg::ST_EMIT;
						end
					end
				end
				chacha_pkg::ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						half_q <= half_q + chacha_pkg::HALF_W'(1);
						if (last_half) begin
							state_q <= chacha_pkg::ST_FINAL;
						end
					end
				end
				chacha_pkg::ST_FINAL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= chacha_pkg::ST_EMIT;
					end
				end
				chacha_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= chacha_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= chacha_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register: advance when free, drop valid on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == chacha_pkg::ST_EMIT && out_free) begin
			result_valid <= 1'b1;
		end else if (result_xfer) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == chacha_pkg::ST_EMIT && out_free) begin
			out_word        <= (item_word_q ^ w_q[item_idx_q[3:2]][item_idx_q[1:0]])
				& chacha_pkg::byte_mask(item_bytes_q);
			out_valid_bytes <= item_bytes_q;
			out_last        <= item_last_q;
		end
	end

	// Checks
	a_block_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(data_xfer && need_block) |=> (state_q == chacha_pkg::ST_ROUND))
		else $error("block-opening word did not start the rounds");

	a_final_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chacha_pkg::ST_FINAL && step_q == 2'd3) |=>
		(state_q == chacha_pkg::ST_EMIT))
		else $error("final add did not end in emit");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == chacha_pkg::ST_EMIT))
		else $error("result raised outside emit");

	a_zero_bytes_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_valid_bytes == 3'd0) |-> (out_word == 32'd0))
		else $error("word with no valid bytes is not zero");

endmodule
